// ===== rtl/i2a_fmt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_fmt_pkg
// Shared types and constants of the integer-to-ASCII field formatter.
// ----------------------------------------------------------------------------
package i2a_fmt_pkg;

  // operand and digit chain geometry
  localparam int VAL_W   = 64;
  localparam int BCNT_W  = $clog2(VAL_W);
  localparam int NCELL   = 20;               // 2^64 < 10^20
  localparam int ND_W    = $clog2(NCELL + 1);

  // conversion kinds (op field)
  localparam logic [1:0] OP_SDEC = 2'd0;
  localparam logic [1:0] OP_UDEC = 2'd1;
  localparam logic [1:0] OP_LHEX = 2'd2;
  localparam logic [1:0] OP_UHEX = 2'd3;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SETUP,
    ST_SPACES,
    ST_SIGN,
    ST_ZEROS,
    ST_PRE0,
    ST_PREX,
    ST_DIGS,
    ST_TRAIL
  } fmt_state_t;

  // control broadcast to every digit cell
  typedef struct packed {
    logic clr;        // clear digit
    logic shift_bit;  // shift one binary bit in (with BCD correction if dec)
    logic shift_dig;  // take the neighbour's digit
    logic dec;        // decimal mode: add-3 correction active
  } cell_ctl_t;

endpackage

// ===== rtl/i2a_fmt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_fmt_cell
// One digit cell of the conversion chain: shift-add-3 BCD step or plain
// nibble shift, and whole-digit shift towards the top of the chain.
// ----------------------------------------------------------------------------
module i2a_fmt_cell
  import i2a_fmt_pkg::*;
(
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       bit_in,
  input  logic [3:0] dig_in,
  output logic       bit_out,
  output logic [3:0] dig_q
);

  logic [3:0] dig_r;
  logic [3:0] dig_nxt;
  logic [3:0] adj;

  // add 3 ahead of the shift when the digit would overflow past 9
  assign adj     = (ctl.dec && (dig_r >= 4'd5)) ? (dig_r + 4'd3) : dig_r;
  assign bit_out = adj[3];
  assign dig_q   = dig_r;

  always_comb begin
    dig_nxt = dig_r;
    if (ctl.clr) begin
      dig_nxt = 4'd0;
    end else if (ctl.shift_bit) begin
      dig_nxt = {adj[2:0], bit_in};
    end else if (ctl.shift_dig) begin
      dig_nxt = dig_in;
    end
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

endmodule

// ===== rtl/integer_to_ascii_field_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_field_formatter
// printf-style integer conversion (%d, %u, %x, %X) with padding and
// justification, one character per output beat.
// ----------------------------------------------------------------------------
// One conversion is handled at a time. After the input beat, all 64 operand
// bits are shifted one by one through a chain of 20 digit cells
// (shift-add-3 for decimal, plain nibbles for hex), then leading zero digits
// are shifted out of the top cell one at a time, a setup state works out
// the padding, and the field goes out at one character per cycle while
// out_tready is high. The field has as many characters as the larger of the
// field width and the text length. A new input beat is taken once the last
// character has been accepted.
// ----------------------------------------------------------------------------
module integer_to_ascii_field_formatter
  import i2a_fmt_pkg::*;
#(
  parameter int MAX_WIDTH = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  // [63:0] value, [64] hex_prefix, [65] zero_pad, [66] left_justify,
  // [72:67] field_width, [79:73] zero
  input  logic [79:0] in_tdata,
  // [1:0] op
  input  logic [1:0]  in_tuser,
  // output beat
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] char_out
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);

  localparam logic [5:0] WMAX = 6'(MAX_WIDTH);

  // input fields
  logic [VAL_W-1:0] in_value;
  logic             in_prefix, in_zero, in_left;
  logic [5:0]       in_width;
  logic             in_hex, in_neg;

  assign in_value  = in_tdata[63:0];
  assign in_prefix = in_tdata[64];
  assign in_zero   = in_tdata[65];
  assign in_left   = in_tdata[66];
  assign in_width  = in_tdata[72:67];
  assign in_hex    = (in_tuser == OP_LHEX) || (in_tuser == OP_UHEX);
  assign in_neg    = (in_tuser == OP_SDEC) && in_value[VAL_W-1];

  // registers
  fmt_state_t        state_r, state_nxt;
  logic [VAL_W-1:0]  mag_r, mag_nxt;
  logic [BCNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [ND_W-1:0]   nd_r, nd_nxt;
  logic [5:0]        pad_cnt_r, pad_cnt_nxt;
  logic [5:0]        rem_r, rem_nxt;
  logic [5:0]        width_r, width_nxt;
  logic              neg_r, neg_nxt;
  logic              pfx_r, pfx_nxt;
  logic              zero_r, zero_nxt;
  logic              left_r, left_nxt;
  logic              hex_r, hex_nxt;
  logic              upper_r, upper_nxt;

  // handshakes
  logic in_beat, out_beat;
  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  // digit chain
  cell_ctl_t  cell_ctl;
  logic       chain_bit [NCELL];
  logic [3:0] chain_dig [NCELL];
  logic [3:0] top_dig;

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        i2a_fmt_cell u_cell (
          .clk     (clk),
          .ctl     (cell_ctl),
          .bit_in  (mag_r[VAL_W-1]),
          .dig_in  (4'd0),
          .bit_out (chain_bit[gi]),
          .dig_q   (chain_dig[gi])
        );
      end else begin : g_rest
        i2a_fmt_cell u_cell (
          .clk     (clk),
          .ctl     (cell_ctl),
          .bit_in  (chain_bit[gi-1]),
          .dig_in  (chain_dig[gi-1]),
          .bit_out (chain_bit[gi]),
          .dig_q   (chain_dig[gi])
        );
      end
    end
  endgenerate

  assign top_dig = chain_dig[NCELL-1];

  // leading zero still at the top of the chain
  logic norm_shift;
  assign norm_shift = (top_dig == 4'd0) && (nd_r > ND_W'(1));

  // text length and padding
  logic [5:0] len_c, pad_c, total_c;
  assign len_c   = 6'(nd_r) + {5'd0, neg_r} + (pfx_r ? 6'd2 : 6'd0);
  assign pad_c   = (width_r > len_c) ? (width_r - len_c) : 6'd0;
  assign total_c = pad_c + len_c;

  logic pad_nz_setup, pad_nz;
  assign pad_nz_setup = (pad_c != 6'd0);
  assign pad_nz       = (pad_cnt_r != 6'd0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (bit_cnt_r == BCNT_W'(VAL_W - 1)) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (!norm_shift) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        if (!left_r && !zero_r && pad_nz_setup) state_nxt = ST_SPACES;
        else if (neg_r)                          state_nxt = ST_SIGN;
        else if (zero_r && pad_nz_setup)         state_nxt = ST_ZEROS;
        else if (pfx_r)                          state_nxt = ST_PRE0;
        else                                     state_nxt = ST_DIGS;
      end
      ST_SPACES: begin
        if (out_beat && (pad_cnt_r == 6'd1)) begin
          if (neg_r)      state_nxt = ST_SIGN;
          else if (pfx_r) state_nxt = ST_PRE0;
          else            state_nxt = ST_DIGS;
        end
      end
      ST_SIGN: begin
        if (out_beat) begin
          if (zero_r && pad_nz) state_nxt = ST_ZEROS;
          else if (pfx_r)       state_nxt = ST_PRE0;
          else                  state_nxt = ST_DIGS;
        end
      end
      ST_ZEROS: begin
        if (out_beat && (pad_cnt_r == 6'd1)) state_nxt = pfx_r ? ST_PRE0 : ST_DIGS;
      end
      ST_PRE0: begin
        if (out_beat) state_nxt = ST_PREX;
      end
      ST_PREX: begin
        if (out_beat) state_nxt = ST_DIGS;
      end
      ST_DIGS: begin
        if (out_beat && (nd_r == ND_W'(1))) state_nxt = (left_r && pad_nz) ? ST_TRAIL : ST_IDLE;
      end
      ST_TRAIL: begin
        if (out_beat && (pad_cnt_r == 6'd1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    mag_nxt     = mag_r;
    bit_cnt_nxt = bit_cnt_r;
    nd_nxt      = nd_r;
    pad_cnt_nxt = pad_cnt_r;
    rem_nxt     = rem_r;
    width_nxt   = width_r;
    neg_nxt     = neg_r;
    pfx_nxt     = pfx_r;
    zero_nxt    = zero_r;
    left_nxt    = left_r;
    hex_nxt     = hex_r;
    upper_nxt   = upper_r;
    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          mag_nxt     = in_neg ? (VAL_W'(0) - in_value) : in_value;
          bit_cnt_nxt = '0;
          nd_nxt      = ND_W'(NCELL);
          width_nxt   = (in_width > WMAX) ? WMAX : in_width;
          neg_nxt     = in_neg;
          pfx_nxt     = in_hex && in_prefix;
          zero_nxt    = in_zero && !in_left;
          left_nxt    = in_left;
          hex_nxt     = in_hex;
          upper_nxt   = (in_tuser == OP_UHEX);
        end
      end
      ST_CONV: begin
        mag_nxt     = {mag_r[VAL_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + BCNT_W'(1);
      end
      ST_NORM: begin
        if (norm_shift) nd_nxt = nd_r - ND_W'(1);
      end
      ST_SETUP: begin
        pad_cnt_nxt = pad_c;
        rem_nxt     = total_c;
      end
      default: begin
        if (out_beat) begin
          rem_nxt = rem_r - 6'd1;
          if ((state_r == ST_SPACES) || (state_r == ST_ZEROS) || (state_r == ST_TRAIL)) begin
            pad_cnt_nxt = pad_cnt_r - 6'd1;
          end
          if (state_r == ST_DIGS) nd_nxt = nd_r - ND_W'(1);
        end
      end
    endcase
  end

  // digit to ASCII
  logic [7:0] dig_char;
  always_comb begin
    if (top_dig < 4'd10) dig_char = CH_ZERO + {4'd0, top_dig};
    else                 dig_char = (upper_r ? CH_UA : CH_LA) + {4'd0, top_dig} - 8'd10;
  end

  // outputs and cell control
  always_comb begin
    in_tready          = 1'b0;
    out_tvalid         = 1'b0;
    out_tdata          = CH_SPACE;
    out_tlast          = (rem_r == 6'd1);
    cell_ctl.clr       = 1'b0;
    cell_ctl.shift_bit = 1'b0;
    cell_ctl.shift_dig = 1'b0;
    cell_ctl.dec       = !hex_r;
    case (state_r)
      ST_IDLE: begin
        in_tready    = 1'b1;
        cell_ctl.clr = in_beat;
      end
      ST_CONV:   cell_ctl.shift_bit = 1'b1;
      ST_NORM:   cell_ctl.shift_dig = norm_shift;
      ST_SETUP:  ;
      ST_SPACES: begin
        out_tvalid = 1'b1;
        out_tdata  = CH_SPACE;
      end
      ST_SIGN: begin
        out_tvalid = 1'b1;
        out_tdata  = CH_MINUS;
      end
      ST_ZEROS, ST_PRE0: begin
        out_tvalid = 1'b1;
        out_tdata  = CH_ZERO;
      end
      ST_PREX: begin
        out_tvalid = 1'b1;
        out_tdata  = CH_X;
      end
      ST_DIGS: begin
        out_tvalid         = 1'b1;
        out_tdata          = dig_char;
        cell_ctl.shift_dig = out_beat;
      end
      ST_TRAIL: begin
        out_tvalid = 1'b1;
        out_tdata  = CH_SPACE;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    nd_r      <= nd_nxt;
    pad_cnt_r <= pad_cnt_nxt;
    rem_r     <= rem_nxt;
    width_r   <= width_nxt;
    neg_r     <= neg_nxt;
    pfx_r     <= pfx_nxt;
    zero_r    <= zero_nxt;
    left_r    <= left_nxt;
    hex_r     <= hex_nxt;
    upper_r   <= upper_nxt;
  end

`ifndef ASSERT_OFF
  // input and output sides never active together
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while characters pending");

  // input beat starts conversion, nothing emitted next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> (!in_tready && !out_tvalid))
    else $error("not busy after input beat");

  // final character returns the block to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && out_tlast) |=> in_tready)
    else $error("not idle after last character");

  // remaining characters cover remaining digits
  a_rem_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGS) |-> ((6'(nd_r) <= rem_r) && (nd_r != ND_W'(0))))
    else $error("character count out of step with digits");

  // conversion length fixed at the operand width
  a_conv_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_CONV) && (bit_cnt_r == BCNT_W'(VAL_W - 1))) |=> (state_r == ST_NORM))
    else $error("conversion did not end after all bits");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the integer-to-ASCII field formatter. A short table of
// directed conversions (extremes, every conversion kind, padding corners) is
// followed by random conversions over four idling phases: none, sender idle,
// receiver stalling, and both at once. Every output beat is checked in order
// against table text or an in-bench printf-style integer formatting model.
// ----------------------------------------------------------------------------
module testbench
  import i2a_fmt_pkg::*;
();

  localparam int FIELD_MAX    = 63;    // width saturation limit
  localparam int N_DIR        = 22;
  localparam int RAND_PER_PH  = 80;    // four phases, about 320 conversions
  localparam int STALL_LIMIT  = 3000;  // cycles without any beat
  localparam int DRAIN_CYCLES = 200;

  // one conversion request
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic        hex_prefix;
    logic        zero_pad;
    logic        left_justify;
    logic [5:0]  field_width;
  } conv_t;

  // one expected character beat
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  // directed row: empty text means the model works the field out
  typedef struct {
    conv_t conv;
    string want;
  } dir_row_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_tvalid    = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata     = '0;
  logic [1:0]  in_tuser     = '0;
  logic        out_tvalid;
  logic        out_tready   = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  field_char_t expected_chars[$];
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          n_conv         = 0;
  int          n_chars        = 0;
  int          n_fields_done  = 0;
  int          n_errors       = 0;
  int          idle_cycles    = 0;

  dir_row_t dir_tab [N_DIR] = '{
    '{'{OP_SDEC, 64'd0, 1'b0, 1'b0, 1'b0, 6'd0}, "0"},
    '{'{OP_UDEC, 64'd0, 1'b0, 1'b1, 1'b0, 6'd0}, "0"},
    '{'{OP_SDEC, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 1'b0, 6'd0}, "-9223372036854775808"},
    '{'{OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0}, "18446744073709551615"},
    '{'{OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0}, "-1"},
    '{'{OP_LHEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b0, 6'd0}, "0xffffffffffffffff"},
    '{'{OP_UHEX, 64'h0000_0000_00AB_CDEF, 1'b0, 1'b0, 1'b0, 6'd0}, "ABCDEF"},
    '{'{OP_LHEX, 64'h1F, 1'b1, 1'b1, 1'b0, 6'd6}, "000x1f"},
    '{'{OP_SDEC, 64'hFFFF_FFFF_FFFF_FFD6, 1'b0, 1'b1, 1'b0, 6'd6}, "-00042"},
    '{'{OP_SDEC, 64'd42, 1'b0, 1'b0, 1'b0, 6'd5}, "   42"},
    '{'{OP_SDEC, 64'd42, 1'b0, 1'b1, 1'b1, 6'd5}, "42   "},
    '{'{OP_UDEC, 64'd7, 1'b1, 1'b0, 1'b0, 6'd0}, "7"},
    '{'{OP_SDEC, 64'd123456, 1'b0, 1'b0, 1'b0, 6'd3}, "123456"},
    '{'{OP_LHEX, 64'd0, 1'b1, 1'b0, 1'b0, 6'd0}, "0x0"},
    '{'{OP_UHEX, 64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 1'b0, 6'd0}, "0x123456789ABCDEF"},
    '{'{OP_UDEC, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd0}, "9223372036854775807"},
    '{'{OP_SDEC, 64'h8000_0000_0000_0000, 1'b0, 1'b1, 1'b0, 6'd63}, ""},
    '{'{OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, 6'd63}, ""},
    '{'{OP_LHEX, 64'hDEAD_BEEF, 1'b1, 1'b0, 1'b1, 6'd63}, ""},
    '{'{OP_UHEX, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0, 6'd63}, ""},
    '{'{OP_SDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1, 6'd40}, ""},
    '{'{OP_LHEX, 64'hFEDC_BA98_7654_3210, 1'b0, 1'b1, 1'b0, 6'd20}, ""}
  };

  integer_to_ascii_field_formatter #(.MAX_WIDTH(FIELD_MAX)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Format one conversion and queue its characters
  function automatic void predict_field(input conv_t c);
    logic [7:0]  body[$];
    logic [7:0]  field[$];
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] d;
    logic        neg;
    logic        is_hex;
    logic        zeros;
    int unsigned w;
    int unsigned pad;
    int unsigned start;
    neg    = (c.op == OP_SDEC) && c.value[63];
    is_hex = (c.op == OP_LHEX) || (c.op == OP_UHEX);
    mag    = neg ? (64'd0 - c.value) : c.value;
    radix  = is_hex ? 64'd16 : 64'd10;
    // digits, most significant first
    do begin
      d = mag % radix;
      if (d < 64'd10)
        body.push_front(CH_ZERO + d[7:0]);
      else
        body.push_front(((c.op == OP_UHEX) ? CH_UA : CH_LA) + d[7:0] - 8'd10);
      mag = mag / radix;
    end while (mag != 64'd0);
    if (is_hex && c.hex_prefix) begin
      body.push_front(CH_X);
      body.push_front(CH_ZERO);
    end
    if (neg)
      body.push_front(CH_MINUS);
    w     = (c.field_width > FIELD_MAX) ? FIELD_MAX : c.field_width;
    pad   = (w > body.size()) ? w - body.size() : 0;
    zeros = c.zero_pad && !c.left_justify;
    start = 0;
    if (!c.left_justify && !zeros)
      repeat (pad) field.push_back(CH_SPACE);
    // zero fill goes after the sign, ahead of any prefix
    if (zeros) begin
      if (neg) begin
        field.push_back(CH_MINUS);
        start = 1;
      end
      repeat (pad) field.push_back(CH_ZERO);
    end
    for (int i = start; i < body.size(); i++)
      field.push_back(body[i]);
    if (c.left_justify)
      repeat (pad) field.push_back(CH_SPACE);
    foreach (field[i])
      expected_chars.push_back('{field[i], i == field.size() - 1});
  endfunction

  // Random operand, biased towards boundaries
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    int          k;
    k = $urandom_range(0, 63);
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = 64'hFFFF_FFFF_FFFF_FFFF;
      2: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 1));
      3: v = 64'($urandom_range(0, 99));
      4: v = 64'd0 - 64'($urandom_range(1, 1000));
      5: v = (64'd1 << k) - 64'($urandom_range(0, 1));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic conv_t pick_conv();
    conv_t c;
    c.op           = 2'($urandom_range(0, 3));
    c.value        = pick_value();
    c.hex_prefix   = 1'($urandom_range(0, 1));
    c.zero_pad     = 1'($urandom_range(0, 1));
    c.left_justify = 1'($urandom_range(0, 1));
    // mostly narrow fields, a few wide ones
    if ($urandom_range(0, 4) != 0)
      c.field_width = 6'($urandom_range(0, 24));
    else
      c.field_width = 6'($urandom_range(25, FIELD_MAX));
    return c;
  endfunction

  // Present one request and wait for its beat
  task automatic send_conv(input conv_t c, input string want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, c.field_width, c.left_justify, c.zero_pad, c.hex_prefix, c.value};
    in_tuser  <= c.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (want.len() != 0) begin
      for (int i = 0; i < want.len(); i++)
        expected_chars.push_back('{want.getc(i), i == want.len() - 1});
    end else begin
      predict_field(c);
    end
    n_conv++;
  endtask

  // Receiver: check each character beat, then choose next ready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, out_tdata, out_tlast);
        n_errors++;
      end else begin
        if (out_tdata !== expected_chars[0].ch || out_tlast !== expected_chars[0].last) begin
          $display("%0t: field %0d: expected char %h last %b, got char %h last %b", $time,
                   n_fields_done, expected_chars[0].ch, expected_chars[0].last,
                   out_tdata, out_tlast);
          n_errors++;
        end
        if (expected_chars[0].last)
          n_fields_done++;
        void'(expected_chars.pop_front());
      end
      n_chars++;
    end
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("integer_to_ascii_field_formatter: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    int sender_pct [4];
    int stall_pct [4];
    sender_pct = '{0, 74, 0, 18};
    stall_pct  = '{0, 0, 74, 18};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, no idling
    for (int i = 0; i < N_DIR; i++)
      send_conv(dir_tab[i].conv, dir_tab[i].want);

    // random conversions over the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = sender_pct[ph];
      recv_stall_pct = stall_pct[ph];
      for (int n = 0; n < RAND_PER_PH; n++)
        send_conv(pick_conv(), "");
    end
    in_tvalid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d conversions (%0d characters) over all four kinds, padding modes",
             n_conv, n_chars);
    $display("and idling phases; %0d errors seen.", n_errors);
    if (n_errors == 0 && expected_chars.size() == 0)
      $display("integer_to_ascii_field_formatter: match");
    else
      $display("integer_to_ascii_field_formatter: mismatch");
    $finish;
  end

endmodule
